[sv/u8n1_pkg.sv]
package u8n1_pkg;

	localparam int unsigned DATA_W         = 8;
	localparam int unsigned PERIOD_W       = 16;
	localparam int unsigned FIFO_DEPTH_DEF = 16;
	localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = PERIOD_W'(104);

	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned M_TDATA_W = 16;

	// serial frame positions: transmit counted from the leading idle bit, receive from the start bit
	localparam logic [3:0] TX_POS_START = 4'd1;
	localparam logic [3:0] TX_POS_D7    = 4'd9;
	localparam logic [3:0] RX_POS_D7    = 4'd8;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_POP  = 2'd1,
		ACT_SEND = 2'd2,
		ACT_RSVD = 2'd3
	} action_t;

	// decoded input word handed from the front end to the back end
	typedef struct packed {
		logic              pop;
		logic              send;
		logic [DATA_W-1:0] tx_byte;
		logic              rx_line;
	} item_t;

	typedef struct packed {
		logic                done;
		logic [PERIOD_W-1:0] count;
	} wait_t;

	// one tick of a bit timer; done once the count reaches target
	function automatic wait_t wait_step(input logic [PERIOD_W-1:0] count,
			input logic [PERIOD_W-1:0] target);
		logic [PERIOD_W:0] c;
		wait_t             w;
		c = {1'b0, count} + 1'b1;
		if (c >= {1'b0, target}) begin
			w.done  = 1'b1;
			w.count = '0;
		end else begin
			w.done  = 1'b0;
			w.count = c[PERIOD_W-1:0];
		end
		return w;
	endfunction

endpackage

[sv/u8n1_front.sv]
module u8n1_front
	import u8n1_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // action[1:0], tx_byte[9:2], rx_line[10]
	input  logic                 deq,
	output logic                 head_valid,
	output item_t                head
);

	item_t      entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	item_t      dec;
	logic       push;

	always_comb begin
		dec.tx_byte = s_tdata[9:2];
		dec.rx_line = s_tdata[10];
		dec.pop     = 1'b0;
		dec.send    = 1'b0;
		unique case (action_t'(s_tdata[1:0]))
			ACT_POP:  dec.pop  = 1'b1;
			ACT_SEND: dec.send = 1'b1;
			ACT_TICK, ACT_RSVD: ;
			default: ;
		endcase
	end

	assign s_tready   = (count_q != 2'd2);
	assign push       = s_tvalid && s_tready;
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (deq) rd_q <= ~rd_q;
			count_q <= count_q + {1'b0, push} - {1'b0, deq};
		end
	end

endmodule

[sv/u8n1_rx.sv]
module u8n1_rx
	import u8n1_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  item_t               item,
	input  logic [PERIOD_W-1:0] bit_period,
	output logic [DATA_W-1:0]   rx_data,
	output logic                rx_available
);

	localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	logic [DATA_W-1:0]   mem [FIFO_DEPTH];
	logic [PW-1:0]       wp_q, rp_q, wp_n, rp_n;
	logic                active_q, active_n;
	logic [PERIOD_W-1:0] tick_q, tick_n;
	logic [3:0]          bits_q, bits_n;
	logic [DATA_W-1:0]   shift_q, shift_n;
	logic [DATA_W-1:0]   rx_data_q;
	logic                pop_ok;
	logic                store;
	wait_t               w;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		active_n = active_q;
		tick_n   = tick_q;
		bits_n   = bits_q;
		shift_n  = shift_q;
		wp_n     = wp_q;
		store    = 1'b0;
		pop_ok   = item.pop && (rp_q != wp_q);
		rp_n     = pop_ok ? ring_next(rp_q) : rp_q;
		w        = wait_step(tick_q, (bits_q == 4'd0) ? (bit_period >> 1) : bit_period);
		if (!active_q) begin
			if (!item.rx_line) begin
				active_n = 1'b1;
				tick_n   = '0;
				bits_n   = 4'd0;
			end
		end else begin
			tick_n = w.count;
			if (w.done) begin
				priority if (bits_q == 4'd0) begin
					bits_n = 4'd1;
				end else if (bits_q <= RX_POS_D7) begin
					shift_n = {item.rx_line, shift_q[DATA_W-1:1]};
					bits_n  = bits_q + 1'b1;
				end else begin
					// stop bit waited out, not checked
					wp_n     = ring_next(wp_q);
					store    = 1'b1;
					active_n = 1'b0;
					bits_n   = 4'd0;
				end
			end
		end
	end

	// pop reads rp+1 and store writes wp+1; they never collide while rp != wp
	always_ff @(posedge clk) begin
		if (step && store) mem[wp_n] <= shift_q;
		if (step) rx_data_q <= pop_ok ? mem[rp_n] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			tick_q   <= '0;
			bits_q   <= 4'd0;
			shift_q  <= '0;
			wp_q     <= '0;
			rp_q     <= '0;
		end else if (step) begin
			active_q <= active_n;
			tick_q   <= tick_n;
			bits_q   <= bits_n;
			shift_q  <= shift_n;
			wp_q     <= wp_n;
			rp_q     <= rp_n;
		end
	end

	assign rx_data      = rx_data_q;
	assign rx_available = (rp_q != wp_q);

endmodule

[sv/u8n1_tx.sv]
module u8n1_tx
	import u8n1_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  item_t               item,
	input  logic [PERIOD_W-1:0] bit_period,
	output logic                tx_line,
	output logic                tx_busy
);

	logic                active_q, active_e, active_n;
	logic [PERIOD_W-1:0] tick_q, tick_e, tick_n;
	logic [3:0]          bits_q, bits_e, bits_n;
	logic [DATA_W-1:0]   shift_q, shift_e, shift_n;
	logic                line_q, line_n;
	logic                start;
	wait_t               w;

	always_comb begin
		// a send accepted while idle starts the leading idle bit on this tick
		start    = item.send && !active_q;
		active_e = start ? 1'b1       : active_q;
		tick_e   = start ? '0         : tick_q;
		bits_e   = start ? 4'd0       : bits_q;
		shift_e  = start ? item.tx_byte : shift_q;
		active_n = active_e;
		tick_n   = tick_e;
		bits_n   = bits_e;
		shift_n  = shift_e;
		line_n   = 1'b1;
		w        = wait_step(tick_e, bit_period);
		if (active_e) begin
			priority if (bits_e == 4'd0)          line_n = 1'b1;
			else if (bits_e == TX_POS_START)      line_n = 1'b0;
			else if (bits_e <= TX_POS_D7)         line_n = shift_e[0];
			else                                  line_n = 1'b1;
			tick_n = w.count;
			if (w.done) begin
				if (bits_e > TX_POS_START && bits_e <= TX_POS_D7)
					shift_n = shift_e >> 1;
				if (bits_e > TX_POS_D7) begin
					active_n = 1'b0;
					bits_n   = 4'd0;
				end else begin
					bits_n = bits_e + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			tick_q   <= '0;
			bits_q   <= 4'd0;
			shift_q  <= '0;
			line_q   <= 1'b1;
		end else if (step) begin
			active_q <= active_n;
			tick_q   <= tick_n;
			bits_q   <= bits_n;
			shift_q  <= shift_n;
			line_q   <= line_n;
		end
	end

	assign tx_line = line_q;
	assign tx_busy = active_q;

endmodule

[sv/uart_8n1_with_rx_fifo.sv]
// 8N1 UART, full duplex, with a receive ring FIFO of FIFO_DEPTH bytes. Every input
// word is one tick of bit timing and yields exactly one output word: the transmit
// line level for that tick, the byte popped (0 if none or FIFO empty), whether the
// FIFO holds data, and whether a frame is still being sent. bit_period (reset 104)
// sets ticks per bit; the receiver samples at half a period after the start edge,
// then once per period; the stop bit is not checked and an overrun wraps silently.
// A 2-deep input queue feeds the receiver/transmitter back end, which handles one
// word per clock into an output register, so one word per cycle is sustained;
// the back end stalls only while the output word is not taken.
module uart_8n1_with_rx_fifo
	import u8n1_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // action[1:0], tx_byte[9:2], rx_line[10]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // tx_line[0], rx_data[8:1], rx_available[9],
	                                       // tx_busy[10]
	input  logic                 cfg_wen,
	input  logic [PERIOD_W-1:0]  cfg_wdata
);

	logic [PERIOD_W-1:0] bit_period_q;
	logic                out_valid_q;
	logic                head_valid;
	item_t               head;
	logic                step;
	logic                tx_line, tx_busy, rx_available;
	logic [DATA_W-1:0]   rx_data;

	assign step = head_valid && (!out_valid_q || m_tready);

	u8n1_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.deq        (step),
		.head_valid (head_valid),
		.head       (head)
	);

	u8n1_rx #(.FIFO_DEPTH(FIFO_DEPTH)) u_rx (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.item         (head),
		.bit_period   (bit_period_q),
		.rx_data      (rx_data),
		.rx_available (rx_available)
	);

	u8n1_tx u_tx (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item       (head),
		.bit_period (bit_period_q),
		.tx_line    (tx_line),
		.tx_busy    (tx_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= BIT_PERIOD_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) bit_period_q <= cfg_wdata;
			if (step) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(M_TDATA_W - DATA_W - 3)'(0), tx_busy, rx_available, rx_data, tx_line};

endmodule

[sv/u8n1_chk.sv]
module u8n1_chk
	import u8n1_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output word changed while stalled");

	// input queue fills only behind a stalled output word
	a_full_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no output pending");

	// line is idle high whenever no frame is in flight
	a_idle_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[10] |-> m_tdata[0])
		else $error("tx line low while transmitter idle");

endmodule

bind uart_8n1_with_rx_fifo u8n1_chk u_chk (.*);

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import u8n1_pkg::*;

	typedef struct packed {
		logic        tx_line;
		logic [7:0]  rx_data;
		logic        avail;
		logic        busy;
	} uart_out_t;

	typedef struct packed {
		action_t     act;
		logic [7:0]  tx_byte;
		logic        rx_line;
		logic        typed;
		uart_out_t   want;
	} dir_row_t;

	localparam int N_DIR   = 14;
	localparam int N_PHASE = 8;
	localparam int PH_PERIOD [N_PHASE] = '{2, 0, 1, 3, 5, 16, 65535, 7};
	localparam int PH_ITEMS  [N_PHASE] = '{300, 120, 400, 250, 250, 250, 80, 150};
	localparam int PH_POPPCT [N_PHASE] = '{12, 25, 0, 15, 10, 4, 30, 10};
	localparam int HOLD_CYCLES = 300;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_wen = 1'b0;
	logic [PERIOD_W-1:0]  cfg_wdata = '0;

	uart_8n1_with_rx_fifo u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// predictor state
	logic [15:0] period_q = BIT_PERIOD_RST;
	logic        rx_on = 1'b0;
	logic [15:0] rx_cnt = '0;
	logic [3:0]  rx_pos = '0;
	logic [7:0]  rx_sh = '0;
	logic [7:0]  fifo_mem [16];
	logic [3:0]  wr_ptr = '0;
	logic [3:0]  rd_ptr = '0;
	logic [15:0] tx_cnt = '0;
	logic [3:0]  tx_pos = '0;
	logic [7:0]  tx_sh = '0;
	logic        tx_on = 1'b0;

	uart_out_t pending_out_q [$];
	int        errors = 0;

	// sender / receiver coordination
	int burst_left = 0;
	bit hold_go = 1'b0;
	bit long_hold = 1'b0;

	// receive line waveform generator
	int         seg_pos = 10;
	int         seg_left = 0;
	logic [7:0] frame_byte = '0;
	logic       stop_lvl = 1'b1;

	initial begin
		for (int i = 0; i < 16; i++)
			fifo_mem[i] = '0;
	end

	function automatic logic bit_timer(input logic [15:0] cnt, input logic [15:0] target,
			output logic [15:0] nxt);
		logic [16:0] c;
		c = {1'b0, cnt} + 17'd1;
		if (c >= {1'b0, target}) begin
			nxt = '0;
			return 1'b1;
		end
		nxt = c[15:0];
		return 1'b0;
	endfunction

	function automatic uart_out_t uart_tick(input action_t act, input logic [7:0] b,
			input logic line);
		uart_out_t   o;
		logic        done;
		logic [15:0] nc;
		logic        lvl;
		o = '0;
		// pop sees pointers as they stand at the start of the tick
		if (act == ACT_POP && rd_ptr != wr_ptr) begin
			rd_ptr = rd_ptr + 4'd1;
			o.rx_data = fifo_mem[rd_ptr];
		end
		if (!rx_on) begin
			if (!line) begin
				rx_on = 1'b1;
				rx_cnt = '0;
				rx_pos = '0;
			end
		end else if (rx_pos == 4'd0) begin
			done = bit_timer(rx_cnt, period_q >> 1, nc);
			rx_cnt = nc;
			if (done)
				rx_pos = 4'd1;
		end else if (rx_pos <= 4'd8) begin
			done = bit_timer(rx_cnt, period_q, nc);
			rx_cnt = nc;
			if (done) begin
				rx_sh = {line, rx_sh[7:1]};
				rx_pos = rx_pos + 4'd1;
			end
		end else begin
			done = bit_timer(rx_cnt, period_q, nc);
			rx_cnt = nc;
			if (done) begin
				wr_ptr = wr_ptr + 4'd1;
				fifo_mem[wr_ptr] = rx_sh;
				rx_on = 1'b0;
				rx_pos = '0;
			end
		end
		if (act == ACT_SEND && !tx_on) begin
			tx_on = 1'b1;
			tx_sh = b;
			tx_pos = '0;
			tx_cnt = '0;
		end
		lvl = 1'b1;
		if (tx_on) begin
			if (tx_pos == 4'd1)
				lvl = 1'b0;
			else if (tx_pos >= 4'd2 && tx_pos <= 4'd9)
				lvl = tx_sh[0];
			done = bit_timer(tx_cnt, period_q, nc);
			tx_cnt = nc;
			if (done) begin
				if (tx_pos >= 4'd2 && tx_pos <= 4'd9)
					tx_sh = tx_sh >> 1;
				if (tx_pos >= 4'd10) begin
					tx_on = 1'b0;
					tx_pos = '0;
				end else begin
					tx_pos = tx_pos + 4'd1;
				end
			end
		end
		o.tx_line = lvl;
		o.avail = (rd_ptr != wr_ptr);
		o.busy = tx_on;
		return o;
	endfunction

	// mostly clean 8N1 frames with random gaps; some noise, bad stop bits, cut frames
	function automatic logic next_rx_line();
		int bl;
		bl = (period_q < 16'd2) ? 1 : int'(period_q);
		while (seg_left == 0) begin
			if (seg_pos >= 10) begin
				if ($urandom_range(0, 99) < 12) begin
					seg_pos = 11;
					seg_left = $urandom_range(1, 12);
				end else begin
					seg_pos = 0;
					frame_byte = 8'($urandom);
					stop_lvl = ($urandom_range(0, 99) >= 5);
					seg_left = $urandom_range(0, (bl < 32) ? 2 * bl : 64);
				end
			end else if (seg_pos >= 1 && $urandom_range(0, 99) < 2) begin
				seg_pos = 11;
				seg_left = $urandom_range(1, 12);
			end else begin
				seg_pos++;
				seg_left = bl;
			end
		end
		seg_left--;
		case (seg_pos)
			0:       return 1'b1;
			1:       return 1'b0;
			10:      return stop_lvl;
			11:      return 1'($urandom_range(0, 1));
			default: return frame_byte[seg_pos-2];
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
	endtask

	task automatic push_word(input action_t a, input logic [7:0] b, input logic l,
			input logic typed, input uart_out_t want);
		uart_out_t p;
		int        gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
		end
		burst_left--;
		if (long_hold)
			gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {5'b0, l, b, a};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		p = uart_tick(a, b, l);
		pending_out_q.push_back(typed ? want : p);
	endtask

	task automatic set_period(input logic [15:0] v);
		s_tvalid <= 1'b0;
		while (pending_out_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wdata <= v;
		cfg_wen <= 1'b1;
		@(posedge clk);
		cfg_wen <= 1'b0;
		period_q = v;
		seg_pos = 10;
		seg_left = 0;
	endtask

	// stimulus
	initial begin
		dir_row_t  dir_rows [N_DIR];
		action_t   a;
		int        r;
		uart_out_t none;
		none = '0;
		dir_rows = '{
			'{ACT_TICK, 8'h00, 1'b1, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0}},
			// pop on empty
			'{ACT_POP,  8'hFF, 1'b1, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0}},
			'{ACT_RSVD, 8'hFF, 1'b1, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0}},
			// send starts with the idle bit
			'{ACT_SEND, 8'hFF, 1'b1, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b1}},
			// ignored while busy
			'{ACT_SEND, 8'h00, 1'b1, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b1}},
			'{ACT_TICK, 8'h00, 1'b0, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b1}},
			'{ACT_POP,  8'h55, 1'b0, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b1}},
			'{ACT_TICK, 8'hAA, 1'b1, 1'b0, '0},
			'{ACT_SEND, 8'h55, 1'b0, 1'b0, '0},
			'{ACT_RSVD, 8'h00, 1'b1, 1'b0, '0},
			'{ACT_POP,  8'hAA, 1'b1, 1'b0, '0},
			'{ACT_TICK, 8'hFF, 1'b0, 1'b0, '0},
			'{ACT_SEND, 8'h80, 1'b0, 1'b0, '0},
			'{ACT_POP,  8'h01, 1'b1, 1'b0, '0}
		};
		wait (arst_n === 1'b1);
		repeat (2) @(posedge clk);
		for (int i = 0; i < N_DIR; i++)
			push_word(dir_rows[i].act, dir_rows[i].tx_byte, dir_rows[i].rx_line,
				dir_rows[i].typed, dir_rows[i].want);
		for (int ph = 0; ph < N_PHASE; ph++) begin
			set_period(16'(PH_PERIOD[ph]));
			for (int n = 0; n < PH_ITEMS[ph]; n++) begin
				if (ph == 4 && n == 50)
					hold_go = 1'b1;
				r = $urandom_range(0, 99);
				if (r < PH_POPPCT[ph])
					a = ACT_POP;
				else if (r < PH_POPPCT[ph] + 18)
					a = ACT_SEND;
				else if (r < PH_POPPCT[ph] + 21)
					a = ACT_RSVD;
				else
					a = ACT_TICK;
				push_word(a, 8'($urandom), next_rx_line(), 1'b0, none);
			end
		end
		s_tvalid <= 1'b0;
		while (pending_out_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// receiver: changing stall patterns plus one long hold-off
	initial begin
		int mode;
		int len;
		wait (arst_n === 1'b1);
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(20, 200);
			for (int i = 0; i < len; i++) begin
				@(posedge clk);
				if (hold_go && !long_hold && HOLD_CYCLES > 0 && mode >= 0 && i >= 0
						&& hold_go) begin
					hold_go = 1'b0;
					long_hold = 1'b1;
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					long_hold = 1'b0;
				end else begin
					case (mode)
						0:       m_tready <= 1'b1;
						1:       m_tready <= ($urandom_range(0, 99) >= 30);
						2:       m_tready <= ((i % 4) != 3);
						default: m_tready <= ($urandom_range(0, 99) >= 75);
					endcase
				end
			end
		end
	end

	// output word checker
	always @(posedge clk) begin
		uart_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_out_q.size() == 0) begin
				report_mismatch("unexpected word", int'(m_tdata), 0);
			end else begin
				want = pending_out_q.pop_front();
				if (m_tdata[0] !== want.tx_line)
					report_mismatch("tx_line", int'(m_tdata[0]), int'(want.tx_line));
				if (m_tdata[8:1] !== want.rx_data)
					report_mismatch("rx_data", int'(m_tdata[8:1]), int'(want.rx_data));
				if (m_tdata[9] !== want.avail)
					report_mismatch("rx_available", int'(m_tdata[9]), int'(want.avail));
				if (m_tdata[10] !== want.busy)
					report_mismatch("tx_busy", int'(m_tdata[10]), int'(want.busy));
			end
		end
	end

endmodule

[files.f]
sv/u8n1_pkg.sv
sv/u8n1_front.sv
sv/u8n1_rx.sv
sv/u8n1_tx.sv
sv/uart_8n1_with_rx_fifo.sv
sv/u8n1_chk.sv
sim/tb_top.sv
